// ===== sv/xcr_pkg.sv =====
`default_nettype none

package xcr_pkg;

    localparam int unsigned BlockBytes = 128;
    localparam int unsigned IndexW     = $clog2(BlockBytes);
    localparam int unsigned OffsetW    = 15;

    localparam logic [7:0] ChSoh = 8'h01;
    localparam logic [7:0] ChEot = 8'h04;
    localparam logic [7:0] ChEtb = 8'h17;

    // result codes
    typedef enum logic [2:0] {
        K_DATA = 3'd0,
        K_ACK  = 3'd1,
        K_NAK  = 3'd2,
        K_END  = 3'd3,
        K_JUMP = 3'd4
    } t_kind;

endpackage

`default_nettype wire

// ===== sv/xcr_if.sv =====
`default_nettype none

// input channel: one received byte or one poll tick per word
interface xcr_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] rx_value;

    modport source (output valid, output mode, output rx_value, input ready);
    modport sink   (input valid, input mode, input rx_value, output ready);
endinterface

// output channel: data writes and handshake replies
interface xcr_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [7:0]  data_value;
    logic [14:0] image_offset;

    modport source (output valid, output kind, output data_value, output image_offset,
                    input ready);
    modport sink   (input valid, input kind, input data_value, input image_offset,
                    output ready);
endinterface

`default_nettype wire

// ===== sv/xmodem_checksum_receiver_core.sv =====
// XMODEM receiver, 8-bit arithmetic checksum.
// i_in carries one word per received serial byte (mode 0) or poll tick (mode 1).
// o_out carries at most one result word per input word:
//   data write (byte plus image offset), ACK, NAK, end ACK, end-and-jump ACK.
// Frame: SOH, block number, complement, 128 data bytes, sum of data bytes.
// Data bytes of a well-formed frame go out at once as tentative writes; the
// checksum byte then gives ACK (commit) or NAK (drop).
// Pipeline: an input register, then the frame decoder, then a result register.
// A result is written to the result register as its input word leaves the input
// register; one word per cycle is sustained while o_out does not stall, since the
// decoder is a single pass over the current state.
// A word that gives no result retires even while o_out is stalled; a word that
// gives a result waits in the input register until the result register frees,
// and i_in.ready drops while it waits.
// Reset (synchronous, active low) empties both registers and returns the frame
// state to wait-for-SOH with last accepted block zero.
// EOT and ETB between frames also return the frame state to reset values.

`default_nettype none

module xmodem_checksum_receiver_core (
    input  wire        i_clk,
    input  wire        i_rst_n,
    xcr_in_if.sink     i_in,
    xcr_out_if.source  o_out
);

    import xcr_pkg::*;

    typedef enum logic [2:0] {
        PH_SOH  = 3'd0,
        PH_BLK  = 3'd1,
        PH_CMP  = 3'd2,
        PH_DATA = 3'd3,
        PH_CHK  = 3'd4
    } t_phase;

    // input register
    logic        r_in_valid;
    logic        r_mode;
    logic [7:0]  r_rx;

    // frame state
    t_phase              r_phase,     n_phase;
    logic [7:0]          r_blk,       n_blk;
    logic [7:0]          r_cmp,       n_cmp;
    logic [IndexW-1:0]   r_idx,       n_idx;
    logic [7:0]          r_sum,       n_sum;
    logic                r_started,   n_started;
    logic                r_bad,       n_bad;

    // result register
    logic        r_out_valid;
    t_kind       r_kind;
    logic [7:0]  r_data;
    logic [14:0] r_off;

    logic        has_res;
    t_kind       res_kind;
    logic [7:0]  res_data;
    logic [14:0] res_off;
    logic        fire;
    logic        in_take;

    always_comb begin
        n_phase   = r_phase;
        n_blk     = r_blk;
        n_cmp     = r_cmp;
        n_idx     = r_idx;
        n_sum     = r_sum;
        n_started = r_started;
        n_bad     = r_bad;
        has_res   = 1'b0;
        res_kind  = K_NAK;
        res_data  = 8'd0;
        res_off   = 15'd0;

        if (r_mode) begin
            // poll tick: ask sender to start only while no frame has started since reset or end
            has_res = !r_started;
        end else begin
            unique case (r_phase)
                PH_BLK: begin
                    if (r_rx != r_blk + 8'd1) n_bad = 1'b1;
                    n_phase = PH_CMP;
                end
                PH_CMP: begin
                    if (r_rx != r_cmp - 8'd1) n_bad = 1'b1;
                    n_phase = PH_DATA;
                end
                PH_DATA: begin
                    n_sum = r_sum + r_rx;
                    n_idx = r_idx + 1'b1;
                    if (&r_idx) n_phase = PH_CHK;
                    has_res  = !r_bad;
                    res_kind = K_DATA;
                    res_data = r_rx;
                    res_off  = {r_blk, r_idx};
                end
                PH_CHK: begin
                    n_phase = PH_SOH;
                    n_idx   = '0;
                    n_sum   = 8'd0;
                    has_res = 1'b1;
                    if (!r_bad && r_rx == r_sum) begin
                        n_blk    = r_blk + 8'd1;
                        n_cmp    = r_cmp - 8'd1;
                        res_kind = K_ACK;
                    end else begin
                        n_bad    = 1'b0;
                        res_kind = K_NAK;
                    end
                end
                default: begin
                    // waiting for SOH; stray bytes are dropped
                    n_phase = PH_SOH;
                    if (r_rx == ChSoh) begin
                        n_phase   = PH_BLK;
                        n_started = 1'b1;
                        n_bad     = 1'b0;
                        n_idx     = '0;
                        n_sum     = 8'd0;
                    end else if (r_rx == ChEot || r_rx == ChEtb) begin
                        n_phase   = PH_SOH;
                        n_blk     = 8'd0;
                        n_cmp     = 8'hFF;
                        n_idx     = '0;
                        n_sum     = 8'd0;
                        n_started = 1'b0;
                        n_bad     = 1'b0;
                        has_res   = 1'b1;
                        res_kind  = (r_rx == ChEot) ? K_END : K_JUMP;
                    end
                end
            endcase
        end
    end

    assign fire    = r_in_valid && (!has_res || !r_out_valid || o_out.ready);
    assign in_take = i_in.valid && i_in.ready;

    assign i_in.ready         = !r_in_valid || fire;
    assign o_out.valid        = r_out_valid;
    assign o_out.kind         = r_kind;
    assign o_out.data_value   = r_data;
    assign o_out.image_offset = r_off;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_SOH;
            r_blk       <= 8'd0;
            r_cmp       <= 8'hFF;
            r_idx       <= '0;
            r_sum       <= 8'd0;
            r_started   <= 1'b0;
            r_bad       <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
                r_mode     <= i_in.mode;
                r_rx       <= i_in.rx_value;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end

            // a new result refills the register in the cycle the old one leaves
            if (fire && has_res) begin
                r_out_valid <= 1'b1;
                r_kind      <= res_kind;
                r_data      <= res_data;
                r_off       <= res_off;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            if (fire) begin
                r_phase   <= n_phase;
                r_blk     <= n_blk;
                r_cmp     <= n_cmp;
                r_idx     <= n_idx;
                r_sum     <= n_sum;
                r_started <= n_started;
                r_bad     <= n_bad;
            end
        end
    end

endmodule

`default_nettype wire
